[rtl/core/cgfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the four-direction compass gradient block.
// Depends on nothing; every other file in rtl/core uses it.
package cgfd_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W      = 8;
  localparam int NORM_W     = 8;
  localparam int CODE_W     = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0] FW_RESET = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET = 16'd480;

  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // Mask codes reported as the direction.
  typedef enum logic [CODE_W-1:0] {
    DIR_EAST       = 3'd0,
    DIR_NORTH_EAST = 3'd1,
    DIR_SOUTH      = 3'd6,
    DIR_SOUTH_EAST = 3'd7
  } dir_e;

  // Per-stage control that travels alongside the pixel data.
  typedef struct packed {
    logic pix;       // stage carries a pixel that updates window and line stores
    logic res;       // stage produces a result
    logic interior;  // result is evaluated from the window
    logic last;      // result closes the frame
  } ctl_t;

endpackage

[rtl/core/cgfd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests, results and register writes.
// Depends on cgfd_pkg for the payload widths.
interface cgfd_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [cgfd_pkg::PIX_W-1:0]  pixel_value;

  modport source (output valid, command, pixel_value, input ready);
  modport sink (input valid, command, pixel_value, output ready);
endinterface

interface cgfd_res_if;
  logic                        valid;
  logic                        ready;
  logic [cgfd_pkg::NORM_W-1:0] gradient_norm;
  logic [cgfd_pkg::CODE_W-1:0] direction_code;
  logic                        last_of_frame;

  modport source (output valid, gradient_norm, direction_code, last_of_frame, input ready);
  modport sink (input valid, gradient_norm, direction_code, last_of_frame, output ready);
endinterface

interface cgfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cgfd_pkg::CFG_IDX_W-1:0]  index;
  logic [cgfd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/cgfd_window.sv]
`timescale 1ns / 1ps
// Two line memories and the 3x3 pixel window.
// Depends on cgfd_pkg.
module cgfd_window #(
  parameter int MaxWidth = cgfd_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        shift_i,
  input  logic [$clog2(MaxWidth)-1:0] col_i,
  input  cgfd_pkg::pix_t              pixel_i,
  output cgfd_pkg::pix_t [8:0]        win_o
);
  import cgfd_pkg::*;

  localparam int ColW = $clog2(MaxWidth);

  pix_t upper_mem [MaxWidth];
  pix_t lower_mem [MaxWidth];

  pix_t            up_q;
  pix_t            mid_q;
  pix_t            pix_q;
  logic [ColW-1:0] col_q;
  pix_t [8:0]      win_q;

  // The lower store is read before it is overwritten with the new pixel.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mid_q            <= lower_mem[col_i];
      lower_mem[col_i] <= pixel_i;
      pix_q            <= pixel_i;
      col_q            <= col_i;
    end
  end

  // The upper store takes the old lower value one stage later; consecutive
  // pixels never share a column, so the read and the write never collide.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      up_q <= upper_mem[col_i];
    end
    if (shift_i) begin
      upper_mem[col_q] <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[2] <= up_q;
      win_q[5] <= mid_q;
      win_q[8] <= pix_q;
    end
  end

  assign win_o = win_q;

endmodule

[rtl/core/cgfd_grad.sv]
`timescale 1ns / 1ps
// Mask sums, absolute values, divide by three and best-direction selection.
// Depends on cgfd_pkg.
module cgfd_grad (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  cgfd_pkg::pix_t [8:0] win_i,
  output cgfd_pkg::pix_t       norm_o,
  output cgfd_pkg::dir_e       code_o
);
  import cgfd_pkg::*;

  // Window index is row*3 + column with row 0 on top.
  function automatic logic [9:0] abs_diff(input pix_t a, input pix_t b, input pix_t c,
                                          input pix_t d, input pix_t e, input pix_t f);
    logic [9:0]  pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    pos  = 10'(a) + 10'(b) + 10'(c);
    neg  = 10'(d) + 10'(e) + 10'(f);
    diff = {1'b0, pos} - {1'b0, neg};
    return diff[10] ? 10'(-diff) : diff[9:0];
  endfunction

  // Exact floor(a/3) for a up to 765 by multiplying with 683/2048.
  function automatic pix_t div3(input logic [9:0] a);
    logic [19:0] prod;
    prod = 20'(a) * 20'd683;
    return prod[18:11];
  endfunction

  logic [9:0] abs_q [4];
  pix_t       q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q[0] <= abs_diff(win_i[2], win_i[5], win_i[8], win_i[0], win_i[3], win_i[6]);
      abs_q[1] <= abs_diff(win_i[1], win_i[2], win_i[5], win_i[3], win_i[6], win_i[7]);
      abs_q[2] <= abs_diff(win_i[6], win_i[7], win_i[8], win_i[0], win_i[1], win_i[2]);
      abs_q[3] <= abs_diff(win_i[5], win_i[7], win_i[8], win_i[0], win_i[1], win_i[3]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q[i] = div3(abs_q[i]);
    end
    // A later mask wins only on a strictly larger value.
    norm_o = q[0];
    code_o = DIR_EAST;
    if (q[1] > norm_o) begin
      norm_o = q[1];
      code_o = DIR_NORTH_EAST;
    end
    if (q[2] > norm_o) begin
      norm_o = q[2];
      code_o = DIR_SOUTH;
    end
    if (q[3] > norm_o) begin
      norm_o = q[3];
      code_o = DIR_SOUTH_EAST;
    end
  end

endmodule

[rtl/core/compass_gradient_four_direction_unit.sv]
`timescale 1ns / 1ps
// Top level of the four-direction compass gradient block.
// Depends on cgfd_pkg, cgfd_if, cgfd_window and cgfd_grad.
//
// The block takes one request per clock and returns at most one result per
// request, through a four-stage pipeline: line memory read, window update,
// mask sums, then the registered result. The whole pipeline holds while the
// result register is full and not taken. Results trail the pixel stream by
// the clamped frame width plus one requests; after the last pixel of a
// frame, each flush request returns one of those trailing border results,
// and pixels sent while they are still owed are dropped. The line memories
// are single-port-write, read-first arrays of MaxWidth entries; their
// content needs no clearing after reset.
// Register writes are always ready and should be made while no request is
// in flight.
module compass_gradient_four_direction_unit #(
  parameter int MaxWidth = cgfd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cgfd_pix_if.sink    pix_i,
  cgfd_res_if.source  res_o,
  cgfd_cfg_if.sink    cfg_i
);
  import cgfd_pkg::*;

  localparam int ColW  = $clog2(MaxWidth);
  localparam int WidW  = $clog2(MaxWidth + 1);
  localparam int TailW = $clog2(MaxWidth + 2);

  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [ColW-1:0]  col_q, col_d;
  logic [FH_W-1:0]  row_q, row_d;
  logic [TailW-1:0] tail_q, tail_d;

  logic [WidW-1:0]  eff_w;
  logic [WidW-1:0]  w_last;
  logic [FH_W-1:0]  h_last;

  ctl_t ctl_in;
  ctl_t ctl_a_q, ctl_b_q, ctl_c_q;

  logic en;
  logic accept;
  logic load;
  logic emit;

  logic             out_valid_q;
  pix_t             out_norm_q;
  logic [CODE_W-1:0] out_code_q;
  logic             out_last_q;

  pix_t [8:0] win;
  pix_t       best_norm;
  dir_e       best_code;

  assign en     = !out_valid_q || res_o.ready;
  assign accept = pix_i.valid && en;
  assign load   = accept && !pix_i.command && (tail_q == '0);

  assign pix_i.ready = en;
  assign cfg_i.ready = 1'b1;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (frame_width_q < FW_W'(3)) begin
      eff_w = WidW'(3);
    end else if (32'(frame_width_q) > MaxWidth) begin
      eff_w = WidW'(MaxWidth);
    end else begin
      eff_w = WidW'(frame_width_q);
    end
    w_last = eff_w - WidW'(1);
    h_last = (frame_height_q < FH_W'(3)) ? FH_W'(2) : frame_height_q - FH_W'(1);
  end

  // Classify the incoming request and advance the raster counters.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    tail_d = tail_q;
    ctl_in = '0;
    emit   = (row_q >= FH_W'(2)) || (row_q == FH_W'(1) && col_q != '0);
    if (accept) begin
      if (pix_i.command) begin
        if (tail_q != '0) begin
          tail_d       = tail_q - TailW'(1);
          ctl_in.res   = 1'b1;
          ctl_in.last  = (tail_q == TailW'(1));
        end
      end else if (tail_q == '0) begin
        ctl_in.pix      = 1'b1;
        ctl_in.res      = emit;
        ctl_in.interior = emit && (row_q >= FH_W'(2)) && (row_q <= h_last)
                          && (32'(col_q) >= 2) && (32'(col_q) <= 32'(w_last));
        if (32'(col_q) >= 32'(w_last)) begin
          col_d = '0;
          if (row_q >= h_last) begin
            row_d  = '0;
            tail_d = TailW'(eff_w) + TailW'(1);
          end else begin
            row_d = row_q + FH_W'(1);
          end
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_RESET;
      frame_height_q <= FH_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      tail_q      <= '0;
      ctl_a_q     <= '0;
      ctl_b_q     <= '0;
      ctl_c_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      tail_q <= tail_d;
      if (en) begin
        ctl_a_q     <= ctl_in;
        ctl_b_q     <= ctl_a_q;
        ctl_c_q     <= ctl_b_q;
        out_valid_q <= ctl_c_q.res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_norm_q <= ctl_c_q.interior ? best_norm : '0;
      out_code_q <= ctl_c_q.interior ? best_code : DIR_EAST;
      out_last_q <= ctl_c_q.last;
    end
  end

  cgfd_window #(
    .MaxWidth (MaxWidth)
  ) u_window (
    .clk_i   (clk_i),
    .load_i  (load),
    .shift_i (en && ctl_a_q.pix),
    .col_i   (col_q),
    .pixel_i (pix_i.pixel_value),
    .win_o   (win)
  );

  cgfd_grad u_grad (
    .clk_i  (clk_i),
    .en_i   (en),
    .win_i  (win),
    .norm_o (best_norm),
    .code_o (best_code)
  );

  assign res_o.valid          = out_valid_q;
  assign res_o.gradient_norm  = out_norm_q;
  assign res_o.direction_code = out_code_q;
  assign res_o.last_of_frame  = out_last_q;

endmodule

[tb/sv/cgfd_tb_pkg.sv]
`timescale 1ns / 1ps
// Request command codes shared by the gradient testbench and its checker.
// Depends on nothing.
package cgfd_tb_pkg;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } command_e;

endpackage

[tb/sv/compass_gradient_checker.sv]
`timescale 1ns / 1ps
// Checker for the compass gradient block: mirrors line stores, window and counters,
// predicts each result and compares it with what the block returns.
// Depends on cgfd_pkg, cgfd_tb_pkg and the channel interfaces in cgfd_if.
module compass_gradient_checker
  import cgfd_pkg::*;
  import cgfd_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cgfd_pix_if  pix_i,
  cgfd_res_if  res_i,
  cgfd_cfg_if  cfg_i,
  output int   failures_o,
  output int   pending_o
);

  typedef struct packed {
    logic [NORM_W-1:0] norm;
    dir_e              code;
    logic              last;
  } gradient_t;

  gradient_t       gradient_q[$];
  gradient_t       want;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  pix_t            above_line[MAX_WIDTH_DEF];
  pix_t            prev_line[MAX_WIDTH_DEF];
  pix_t            win[9];
  int unsigned     in_col;
  int unsigned     in_row;
  int unsigned     tail_owed;

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Window tap at offset (dx, dy) from the center, y pointing down.
  function automatic int tap(int dx, int dy);
    return int'(win[(dy + 1) * 3 + (dx + 1)]);
  endfunction

  function automatic int unsigned mask_norm(int sum);
    return (sum < 0 ? -sum : sum) / 3;
  endfunction

  function automatic gradient_t evaluate_window();
    int unsigned best;
    int unsigned v;
    gradient_t   g;
    best = mask_norm(tap(1, -1) + tap(1, 0) + tap(1, 1)
                     - tap(-1, -1) - tap(-1, 0) - tap(-1, 1));
    g.code = DIR_EAST;
    v = mask_norm(tap(0, -1) + tap(1, -1) + tap(1, 0)
                  - tap(-1, 0) - tap(-1, 1) - tap(0, 1));
    if (v > best) begin
      best = v;
      g.code = DIR_NORTH_EAST;
    end
    v = mask_norm(tap(-1, 1) + tap(0, 1) + tap(1, 1)
                  - tap(-1, -1) - tap(0, -1) - tap(1, -1));
    if (v > best) begin
      best = v;
      g.code = DIR_SOUTH;
    end
    v = mask_norm(tap(1, 0) + tap(0, 1) + tap(1, 1)
                  - tap(-1, -1) - tap(0, -1) - tap(-1, 0));
    if (v > best) begin
      best = v;
      g.code = DIR_SOUTH_EAST;
    end
    g.norm = NORM_W'(best);
    g.last = 1'b0;
    return g;
  endfunction

  task automatic take_pixel(input pix_t p);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    pix_t        up;
    pix_t        mid;
    bit          emit;
    gradient_t   g;
    w = active_width();
    h = active_height();
    // Pixels sent while the frame tail is still owed are dropped.
    if (tail_owed != 0) return;
    c = in_col;
    r = in_row;
    if (c < MAX_WIDTH_DEF) begin
      up = above_line[c];
      mid = prev_line[c];
      above_line[c] = mid;
      prev_line[c] = p;
    end else begin
      up = '0;
      mid = '0;
    end
    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = up;
    win[5] = mid;
    win[8] = p;

    emit = (r >= 2) || (r == 1 && c >= 1);
    g.norm = '0;
    g.code = DIR_EAST;
    g.last = 1'b0;
    if (emit && r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) g = evaluate_window();

    if (c >= w - 1) begin
      in_col = 0;
      if (r >= h - 1) begin
        in_row = 0;
        tail_owed = w + 1;
      end else begin
        in_row = r + 1;
      end
    end else begin
      in_col = c + 1;
    end
    if (emit) gradient_q.push_back(g);
  endtask

  task automatic take_flush();
    gradient_t g;
    if (tail_owed == 0) return;
    tail_owed--;
    g.norm = '0;
    g.code = DIR_EAST;
    g.last = (tail_owed == 0);
    gradient_q.push_back(g);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = FW_RESET;
      height_reg = FH_RESET;
      for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
        above_line[i] = '0;
        prev_line[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col = 0;
      in_row = 0;
      tail_owed = 0;
      gradient_q.delete();
      pending_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (gradient_q.size() == 0) begin
          $error("unexpected result: gradient_norm %0d direction_code %0d last_of_frame %0d",
                 res_i.gradient_norm, res_i.direction_code, res_i.last_of_frame);
          failures_o++;
        end else begin
          want = gradient_q.pop_front();
          if (res_i.gradient_norm !== want.norm) begin
            $error("gradient_norm: expected %0d, got %0d", want.norm, res_i.gradient_norm);
            failures_o++;
          end
          if (res_i.direction_code !== want.code) begin
            $error("direction_code: expected %0d, got %0d", want.code, res_i.direction_code);
            failures_o++;
          end
          if (res_i.last_of_frame !== want.last) begin
            $error("last_of_frame: expected %0d, got %0d", want.last, res_i.last_of_frame);
            failures_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_FRAME_WIDTH) width_reg = cfg_i.data[FW_W-1:0];
        else if (cfg_i.index == CFG_FRAME_HEIGHT) height_reg = cfg_i.data[FH_W-1:0];
      end
      if (pix_i.valid && pix_i.ready) begin
        if (pix_i.command == CMD_FLUSH) take_flush();
        else take_pixel(pix_i.pixel_value);
      end
      pending_o = gradient_q.size();
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the compass gradient testbench: clock, reset, request and register traffic,
// result back-pressure and the final verdict.
// Depends on cgfd_pkg, cgfd_tb_pkg, cgfd_if and compass_gradient_checker.
module testbench;
  import cgfd_pkg::*;
  import cgfd_tb_pkg::*;

  localparam int HoldCycles = 300;
  localparam int RandomItems = 400;

  logic clk_i;
  logic rst_ni;
  int   failures;
  int   pending;
  int   idle_mode;
  bit   hold_req;
  int   frame_items;

  cgfd_pix_if pix_ch ();
  cgfd_res_if res_ch ();
  cgfd_cfg_if cfg_ch ();

  compass_gradient_four_direction_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  compass_gradient_checker checker_inst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_ch),
    .res_i      (res_ch),
    .cfg_i      (cfg_ch),
    .failures_o (failures),
    .pending_o  (pending)
  );

  // Directed 3x3 frames in raster order, each aimed at one winning mask or a tie.
  pix_t patterns [6][9] = '{
    '{8'd0,   8'd100, 8'd255, 8'd0,   8'd100, 8'd255, 8'd0,   8'd100, 8'd255},
    '{8'd128, 8'd255, 8'd255, 8'd0,   8'd128, 8'd255, 8'd0,   8'd0,   8'd128},
    '{8'd0,   8'd0,   8'd0,   8'd60,  8'd60,  8'd60,  8'd255, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd128, 8'd0,   8'd128, 8'd255, 8'd128, 8'd255, 8'd255},
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int sender_gap_pct();
    if (idle_mode == 1) return 65;
    if (idle_mode == 3) return 34;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (idle_mode == 2) return 65;
    if (idle_mode == 3) return 34;
    return 0;
  endfunction

  // Half the samples sit at the range ends so that strong edges are common.
  function automatic pix_t random_sample();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned clamp_width(logic [CFG_DATA_W-1:0] raw);
    logic [FW_W-1:0] w;
    w = raw[FW_W-1:0];
    if (w < 3) return 3;
    if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned clamp_height(logic [CFG_DATA_W-1:0] raw);
    return (raw < 3) ? 3 : raw;
  endfunction

  // Result side: random stalls, or one long hold-off counted here. The hold-off
  // starts only once a result is waiting, so the block backs up behind it.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && res_ch.valid) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct());
      end
    end
  end

  task automatic send_request(input command_e cmd, input pix_t value);
    while ($urandom_range(99) < sender_gap_pct()) begin
      @(negedge clk_i);
      pix_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_ch.valid <= 1'b1;
    pix_ch.command <= cmd;
    pix_ch.pixel_value <= value;
    do @(posedge clk_i); while (!pix_ch.ready);
  endtask

  // Stops requests until every owed result has come and the pipeline is empty.
  task automatic drain();
    @(negedge clk_i);
    pix_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // One whole frame and its tail. A pattern index below zero gives random pixels.
  // Noise requests are flushes inside the frame and pixels inside the tail.
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int pattern, input int noise_pct);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(CMD_FLUSH, random_sample());
      send_request(CMD_PIXEL, (pattern >= 0) ? patterns[pattern][i] : random_sample());
      frame_items++;
    end
    for (int unsigned i = 0; i <= w; i++) begin
      if ($urandom_range(99) < noise_pct) send_request(CMD_PIXEL, random_sample());
      send_request(CMD_FLUSH, random_sample());
      frame_items++;
    end
  endtask

  initial begin : stimulus
    int                     frame_idx;
    logic [CFG_DATA_W-1:0]  width_raw;
    logic [CFG_DATA_W-1:0]  height_raw;
    rst_ni = 1'b0;
    hold_req = 1'b0;
    idle_mode = 0;
    frame_items = 0;
    pix_ch.valid = 1'b0;
    pix_ch.command = CMD_PIXEL;
    pix_ch.pixel_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FRAME_WIDTH;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: rows of 640 pixels, then both registers cut mid-frame
    // so the second row ends at once and the frame closes after one more row.
    for (int i = 0; i < 643; i++) send_request(CMD_PIXEL, random_sample());
    drain();
    write_register(CFG_FRAME_WIDTH, 16'd3);
    write_register(CFG_FRAME_HEIGHT, 16'd3);
    for (int i = 0; i < 4; i++) send_request(CMD_PIXEL, random_sample());
    send_request(CMD_PIXEL, 8'hAA);
    for (int i = 0; i < 4; i++) send_request(CMD_FLUSH, 8'h00);
    send_request(CMD_FLUSH, 8'hFF);

    for (int p = 0; p < 6; p++) send_frame(3, 3, p, 0);

    // Width and height below the minimum behave as three.
    drain();
    write_register(CFG_FRAME_WIDTH, 16'h0802);
    write_register(CFG_FRAME_HEIGHT, 16'h0001);
    send_frame(3, 3, -1, 0);

    // Narrower line mid-frame: the current row ends on the next pixel.
    drain();
    write_register(CFG_FRAME_WIDTH, 16'd8);
    write_register(CFG_FRAME_HEIGHT, 16'd6);
    for (int i = 0; i < 22; i++) send_request(CMD_PIXEL, random_sample());
    drain();
    write_register(CFG_FRAME_WIDTH, 16'd4);
    for (int i = 0; i < 13; i++) send_request(CMD_PIXEL, random_sample());
    for (int i = 0; i < 5; i++) send_request(CMD_FLUSH, random_sample());

    // Tallest frame, cut short mid-frame by a height below the minimum.
    drain();
    write_register(CFG_FRAME_WIDTH, 16'd3);
    write_register(CFG_FRAME_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 15; i++) send_request(CMD_PIXEL, random_sample());
    drain();
    write_register(CFG_FRAME_HEIGHT, 16'h0000);
    for (int i = 0; i < 3; i++) send_request(CMD_PIXEL, random_sample());
    for (int i = 0; i < 4; i++) send_request(CMD_FLUSH, random_sample());

    // Widest line: one full row and the start of the next, then the line is cut
    // to three so the second row ends and the frame closes after one more row.
    // The result side holds off long enough to back up the input.
    drain();
    write_register(CFG_FRAME_WIDTH, 16'hFFFF);
    write_register(CFG_FRAME_HEIGHT, 16'd3);
    hold_req = 1'b1;
    for (int i = 0; i < MAX_WIDTH_DEF + 4; i++) send_request(CMD_PIXEL, random_sample());
    drain();
    write_register(CFG_FRAME_WIDTH, 16'd3);
    for (int i = 0; i < 4; i++) send_request(CMD_PIXEL, random_sample());
    for (int i = 0; i < 4; i++) send_request(CMD_FLUSH, random_sample());

    frame_items = 0;
    frame_idx = 0;
    while (frame_items < RandomItems) begin
      idle_mode = frame_idx % 4;
      if (frame_idx == 0 || $urandom_range(3) != 0) begin
        drain();
        if ($urandom_range(7) == 0) width_raw[FW_W-1:0] = FW_W'($urandom_range(2));
        else if ($urandom_range(15) == 0) width_raw[FW_W-1:0] = FW_W'($urandom_range(40, 120));
        else width_raw[FW_W-1:0] = FW_W'($urandom_range(3, 14));
        width_raw[CFG_DATA_W-1:FW_W] = (CFG_DATA_W - FW_W)'($urandom());
        if ($urandom_range(7) == 0) height_raw = CFG_DATA_W'($urandom_range(2));
        else height_raw = CFG_DATA_W'($urandom_range(3, 8));
        write_register(CFG_FRAME_WIDTH, width_raw);
        write_register(CFG_FRAME_HEIGHT, height_raw);
      end
      send_frame(clamp_width(width_raw), clamp_height(height_raw), -1, 8);
      frame_idx++;
    end

    @(negedge clk_i);
    pix_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
